@@ design/vfcc_pkg.sv @@
// Shared types, constants and helpers for the video frame chain carver.
// No dependencies; every other design file imports this package.
package vfcc_pkg;

    localparam int OFFSET_WIDTH_DEF = 32;
    localparam int WIN_LEN          = 20;
    localparam int FILL_W           = 5;
    localparam int LEN_W            = 24;
    localparam int CHAN_W           = 16;
    localparam int TYPE_W           = 16;
    localparam int SEC_W            = 31;
    localparam int GAP_W            = 8;
    localparam int DAYS_W           = 15;
    localparam int HMS_W            = 17;
    localparam int REP_OFS_W        = 32;
    localparam int CFG_IDX_W        = 8;
    localparam int CFG_DATA_W       = 24;
    localparam int M_TDATA_W        = 176;

    // header magic, bytes 0..3
    localparam logic [7:0] MAGIC_B0 = 8'd68;
    localparam logic [7:0] MAGIC_B1 = 8'd72;
    localparam logic [7:0] MAGIC_B2 = 8'd65;
    localparam logic [7:0] MAGIC_B3 = 8'd86;

    // time word limits
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINSEC_MAX = 6'd59;
    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [3:0] MONTH_FEB  = 4'd2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_SECONDS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_TYPE    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHANNEL   = 8'd3;

    localparam logic [LEN_W-1:0]  RST_MAX_FRAME_LEN = 24'd1000000;
    localparam logic [GAP_W-1:0]  RST_GAP_SECONDS   = 8'd2;
    localparam logic [TYPE_W-1:0] RST_START_TYPE    = 16'd253;
    localparam logic [CHAN_W-1:0] RST_MAX_CHANNEL   = 16'd15;

    typedef enum logic [2:0] {
        VD_BAD_TIME      = 3'd0,
        VD_BAD_CHAN      = 3'd1,
        VD_NOT_START     = 3'd2,
        VD_STARTED       = 3'd3,
        VD_CONTINUED     = 3'd4,
        VD_CLOSED_RESTRT = 3'd5,
        VD_CLOSED_IDLE   = 3'd6
    } verdict_t;

    typedef struct packed {
        logic [LEN_W-1:0]  max_len;
        logic [GAP_W-1:0]  gap;
        logic [TYPE_W-1:0] start_type;
        logic [CHAN_W-1:0] max_chan;
    } cfg_t;

    // decoded header candidate after the window stage
    typedef struct packed {
        logic              vld;
        logic              cand_ok;   // magic present and length in range
        logic [LEN_W-1:0]  len;
        logic [CHAN_W-1:0] chan;
        logic              chan_bad;
        logic              is_start;
        logic              time_bad;
        logic [DAYS_W-1:0] days;      // civil day count plus one
        logic [HMS_W-1:0]  hms;
    } hdr_t;

    // candidate with time converted to seconds
    typedef struct packed {
        logic              vld;
        logic              cand_ok;
        logic [LEN_W-1:0]  len;
        logic [CHAN_W-1:0] chan;
        logic              chan_bad;
        logic              is_start;
        logic              time_bad;
        logic [SEC_W-1:0]  secs;
    } cand_t;

    typedef struct packed {
        logic [REP_OFS_W-1:0] cend;
        logic [REP_OFS_W-1:0] cstart;
        logic [SEC_W-1:0]     secs;
        logic [CHAN_W-1:0]    chan;
        logic [LEN_W-1:0]     len;
        logic [REP_OFS_W-1:0] ofs;
        verdict_t             verdict;
    } result_t;

    // days before the first of the month, non-leap year
    function automatic logic [8:0] month_days_before(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

@@ design/video_frame_chain_carver_unit.sv @@
// Video frame chain carver, top level. Bytes move through the window, header and
// candidate registers into the result buffer. Throughput: one byte per cycle, set by the
// four-stage byte pipeline (window, decode, seconds, classify); it stalls only when both
// result buffer entries are full. Reset (aresetn low, synchronous) clears the window
// fill, offsets, skip count, chain state and result buffer, and loads register defaults.
// Depends on vfcc_pkg, vfcc_hdr_front, vfcc_time_stage, vfcc_chain_ctrl, vfcc_out_buf.
module video_frame_chain_carver_unit
    import vfcc_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input byte stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] data_byte
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] verdict, [34:3] frame_offset, [58:35] frame_length,
    // [74:59] channel_number, [105:75] frame_seconds,
    // [137:106] closed_chain_start, [169:138] closed_chain_end, [175:170] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    en;
    hdr_t    hdr;
    cand_t   cand;
    logic    push;
    result_t res;

    // Registers must be written only while the pipeline is empty, so the decode
    // stages may read them directly; the block itself does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_len    <= RST_MAX_FRAME_LEN;
            cfg_reg.gap        <= RST_GAP_SECONDS;
            cfg_reg.start_type <= RST_START_TYPE;
            cfg_reg.max_chan   <= RST_MAX_CHANNEL;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_FRAME_LEN: cfg_reg.max_len    <= cfg_data[LEN_W-1:0];
                REG_GAP_SECONDS:   cfg_reg.gap        <= cfg_data[GAP_W-1:0];
                REG_START_TYPE:    cfg_reg.start_type <= cfg_data[TYPE_W-1:0];
                REG_MAX_CHANNEL:   cfg_reg.max_chan   <= cfg_data[CHAN_W-1:0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // The whole byte pipeline advances together; bubbles flow as invalid
    // stages so the tail of a stream drains without further input.
    assign s_tready = en;

    // stage 1/2: 20-byte window and header field decode
    vfcc_hdr_front u_hdr_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en_i       (en),
        .byte_vld_i (s_tvalid),
        .byte_i     (s_tdata),
        .cfg_i      (cfg_reg),
        .hdr_o      (hdr)
    );

    // stage 3: packed time to seconds since the epoch
    vfcc_time_stage u_time_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en_i    (en),
        .hdr_i   (hdr),
        .cand_o  (cand)
    );

    // stage 4: skip/fill tracking and chain classification
    vfcc_chain_ctrl #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_chain_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en_i    (en),
        .cand_i  (cand),
        .gap_i   (cfg_reg.gap),
        .push_o  (push),
        .res_o   (res)
    );

    // result buffer: keeps taking bytes while one request waits
    vfcc_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_i   (push),
        .res_i    (res),
        .space_o  (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ design/vfcc_hdr_front.sv @@
// Byte window shift line and header field decode (pipeline stages 1 and 2).
// Depends on vfcc_pkg.
module vfcc_hdr_front
    import vfcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en_i,
    input  logic       byte_vld_i,
    input  logic [7:0] byte_i,
    input  cfg_t       cfg_i,
    output hdr_t       hdr_o
);

    logic [7:0] win_reg [WIN_LEN];
    logic       win_vld_reg;
    hdr_t       hdr_reg;
    hdr_t       hdr_next;

    logic [31:0] len32;
    logic [31:0] tword;
    logic [5:0]  yoff;
    logic [3:0]  mon;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec;
    logic [6:0]  y_plus3;
    logic        leap;
    logic        magic_ok;
    logic        len_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_vld_reg <= 1'b0;
            hdr_reg.vld <= 1'b0;
        end else if (en_i) begin
            win_vld_reg <= byte_vld_i;
            hdr_reg     <= hdr_next;
        end
        if (en_i && byte_vld_i) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_LEN-1] <= byte_i;
        end
    end

    always_comb begin
        len32  = {win_reg[15], win_reg[14], win_reg[13], win_reg[12]};
        tword  = {win_reg[19], win_reg[18], win_reg[17], win_reg[16]};
        yoff   = tword[31:26];
        mon    = tword[25:22];
        mday   = tword[21:17];
        hour   = tword[16:12];
        minute = tword[11:6];
        sec    = tword[5:0];

        magic_ok = (win_reg[0] == MAGIC_B0) && (win_reg[1] == MAGIC_B1) &&
                   (win_reg[2] == MAGIC_B2) && (win_reg[3] == MAGIC_B3);
        len_ok   = (len32[31:LEN_W] == '0) && (len32[LEN_W-1:0] <= cfg_i.max_len) &&
                   (len32 >= 32'(WIN_LEN));

        y_plus3 = {1'b0, yoff} + 7'd3;
        leap    = (yoff[1:0] == 2'b00) && (mon > MONTH_FEB);

        hdr_next.vld      = win_vld_reg;
        hdr_next.cand_ok  = magic_ok && len_ok;
        hdr_next.len      = len32[LEN_W-1:0];
        hdr_next.chan     = {win_reg[7], win_reg[6]};
        hdr_next.chan_bad = {win_reg[7], win_reg[6]} > cfg_i.max_chan;
        hdr_next.is_start = {win_reg[5], win_reg[4]} == cfg_i.start_type;
        hdr_next.time_bad = (hour > HOUR_MAX) || (minute > MINSEC_MAX) ||
                            (sec > MINSEC_MAX) || (mon == 4'd0) || (mon > MONTH_MAX);
        // day count is one above the civil count so that it never goes negative
        hdr_next.days     = DAYS_W'(yoff) * DAYS_W'(365) + DAYS_W'(y_plus3[6:2]) +
                            DAYS_W'(month_days_before(mon)) + DAYS_W'(leap) +
                            DAYS_W'(mday);
        hdr_next.hms      = HMS_W'(hour) * HMS_W'(3600) + HMS_W'(minute) * HMS_W'(60) +
                            HMS_W'(sec);
    end

    assign hdr_o = hdr_reg;

endmodule

@@ design/vfcc_time_stage.sv @@
// Converts the day count and time of day to seconds since the epoch (stage 3).
// Depends on vfcc_pkg.
module vfcc_time_stage
    import vfcc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en_i,
    input  hdr_t  hdr_i,
    output cand_t cand_o
);

    cand_t       cand_reg;
    cand_t       cand_next;
    logic [31:0] day_secs;
    logic [31:0] total;

    always_comb begin
        day_secs = 32'(hdr_i.days - DAYS_W'(1)) * 32'd86400;
        total    = day_secs + 32'(hdr_i.hms);

        cand_next.vld      = hdr_i.vld;
        cand_next.cand_ok  = hdr_i.cand_ok;
        cand_next.len      = hdr_i.len;
        cand_next.chan     = hdr_i.chan;
        cand_next.chan_bad = hdr_i.chan_bad;
        cand_next.is_start = hdr_i.is_start;
        cand_next.time_bad = hdr_i.time_bad;
        // day zero of the first month lies before the epoch: clamp to zero
        cand_next.secs     = (hdr_i.days == '0) ? '0 : total[SEC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg.vld <= 1'b0;
        end else if (en_i) begin
            cand_reg <= cand_next;
        end
    end

    assign cand_o = cand_reg;

endmodule

@@ design/vfcc_chain_ctrl.sv @@
// Fill and skip tracking, frame classification and chain state (stage 4).
// Depends on vfcc_pkg.
module vfcc_chain_ctrl
    import vfcc_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en_i,
    input  cand_t            cand_i,
    input  logic [GAP_W-1:0] gap_i,
    output logic             push_o,
    output result_t          res_o
);

    logic [FILL_W-1:0]       fill_reg,       fill_next;
    logic [OFFSET_WIDTH-1:0] ofs_reg,        ofs_next;
    logic [LEN_W-1:0]        skip_reg,       skip_next;
    logic                    in_chain_reg,   in_chain_next;
    logic [CHAN_W-1:0]       last_chan_reg,  last_chan_next;
    logic [SEC_W-1:0]        last_sec_reg,   last_sec_next;
    logic [OFFSET_WIDTH-1:0] first_ofs_reg,  first_ofs_next;
    logic [OFFSET_WIDTH-1:0] last_end_reg,   last_end_next;

    logic                    step;
    logic                    match;
    logic                    take;
    logic                    chain_upd;
    logic [OFFSET_WIDTH-1:0] cur_ofs;
    logic [OFFSET_WIDTH-1:0] end_ofs;
    logic signed [SEC_W+1:0] diff;
    logic                    cont;
    verdict_t                verdict;
    logic [OFFSET_WIDTH-1:0] cstart;
    logic [OFFSET_WIDTH-1:0] cend;

    always_comb begin
        step    = en_i && cand_i.vld;
        cur_ofs = ofs_reg - OFFSET_WIDTH'(WIN_LEN - 1);
        end_ofs = cur_ofs + OFFSET_WIDTH'(cand_i.len);
        match   = (skip_reg == '0) && (fill_reg >= FILL_W'(WIN_LEN - 1)) && cand_i.cand_ok;
        diff    = $signed({2'b00, cand_i.secs}) - $signed({2'b00, last_sec_reg});
        cont    = (diff < $signed({(SEC_W + 2 - GAP_W)'(0), gap_i})) &&
                  (cand_i.chan == last_chan_reg);

        verdict       = VD_NOT_START;
        take          = 1'b0;
        chain_upd     = 1'b0;
        cstart        = '0;
        cend          = '0;
        in_chain_next = in_chain_reg;
        first_ofs_next = first_ofs_reg;

        if (cand_i.time_bad) begin
            verdict = VD_BAD_TIME;
            take    = 1'b1;
        end else if (cand_i.chan_bad) begin
            verdict = VD_BAD_CHAN;
            take    = 1'b1;
        end else if (in_chain_reg) begin
            if (cont) begin
                verdict = VD_CONTINUED;
                take    = 1'b1;
            end else begin
                cstart        = first_ofs_reg;
                cend          = last_end_reg;
                in_chain_next = 1'b0;
                if (cand_i.is_start) begin
                    verdict        = VD_CLOSED_RESTRT;
                    in_chain_next  = 1'b1;
                    first_ofs_next = cur_ofs;
                    take           = 1'b1;
                end else begin
                    verdict = VD_CLOSED_IDLE;
                end
            end
            chain_upd = take;
        end else if (cand_i.is_start) begin
            verdict        = VD_STARTED;
            in_chain_next  = 1'b1;
            first_ofs_next = cur_ofs;
            take           = 1'b1;
            chain_upd      = 1'b1;
        end

        fill_next      = fill_reg;
        ofs_next       = ofs_reg;
        skip_next      = skip_reg;
        last_chan_next = last_chan_reg;
        last_sec_next  = last_sec_reg;
        last_end_next  = last_end_reg;
        push_o         = 1'b0;

        if (step) begin
            ofs_next = ofs_reg + OFFSET_WIDTH'(1);
            if (skip_reg != '0) begin
                skip_next      = skip_reg - LEN_W'(1);
                in_chain_next  = in_chain_reg;
                first_ofs_next = first_ofs_reg;
            end else begin
                if (fill_reg < FILL_W'(WIN_LEN)) begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                if (match) begin
                    push_o = 1'b1;
                    if (chain_upd) begin
                        last_chan_next = cand_i.chan;
                        last_sec_next  = cand_i.secs;
                        last_end_next  = end_ofs;
                    end
                    if (take) begin
                        skip_next = cand_i.len - LEN_W'(WIN_LEN);
                        fill_next = '0;
                    end
                end else begin
                    in_chain_next  = in_chain_reg;
                    first_ofs_next = first_ofs_reg;
                end
            end
        end else begin
            in_chain_next  = in_chain_reg;
            first_ofs_next = first_ofs_reg;
        end

        res_o.verdict = verdict;
        res_o.ofs     = REP_OFS_W'(cur_ofs);
        res_o.len     = cand_i.len;
        res_o.chan    = cand_i.chan;
        res_o.secs    = cand_i.time_bad ? '0 : cand_i.secs;
        res_o.cstart  = REP_OFS_W'(cstart);
        res_o.cend    = REP_OFS_W'(cend);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            ofs_reg       <= '0;
            skip_reg      <= '0;
            in_chain_reg  <= 1'b0;
            last_chan_reg <= '0;
            last_sec_reg  <= '0;
            first_ofs_reg <= '0;
            last_end_reg  <= '0;
        end else begin
            fill_reg      <= fill_next;
            ofs_reg       <= ofs_next;
            skip_reg      <= skip_next;
            in_chain_reg  <= in_chain_next;
            last_chan_reg <= last_chan_next;
            last_sec_reg  <= last_sec_next;
            first_ofs_reg <= first_ofs_next;
            last_end_reg  <= last_end_next;
        end
    end

    // bytes inside a skipped frame never produce a request
    a_skip_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && skip_reg != '0) |-> !push_o)
        else $error("request raised while skipping a frame");

    // a frame taken whole restarts the window from empty
    a_take_clears_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_o && take) |=> (fill_reg == '0))
        else $error("window fill not cleared after a taken frame");

    // chain state only moves on a classified frame
    a_chain_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        !push_o |=> (in_chain_reg == $past(in_chain_reg)) &&
                    (first_ofs_reg == $past(first_ofs_reg)))
        else $error("chain state changed without a classified frame");

endmodule

@@ design/vfcc_out_buf.sv @@
// Two-entry result buffer driving the master-side stream.
// Depends on vfcc_pkg.
module vfcc_out_buf
    import vfcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_i,
    input  result_t              res_i,
    output logic                 space_o,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int PAD_W = M_TDATA_W - $bits(result_t);

    logic [1:0] count_reg, count_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;

    always_comb begin
        pop        = m_tvalid && m_tready;
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop) begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        if (push_i) begin
            if (count_next == 2'd0) begin
                slot0_next = res_i;
            end else begin
                slot1_next = res_i;
            end
            count_next = count_next + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign space_o  = (count_reg != 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {PAD_W'(0), slot0_reg};

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> !push_i)
        else $error("result buffer overflow");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for video_frame_chain_carver_unit: streams raw image bytes, predicts
// each frame verdict from a local copy of the carver state and compares every result.
// Depends on vfcc_pkg and the carver RTL only.
module testbench;
    import vfcc_pkg::*;

    localparam int QUIET_LIMIT   = 4000;  // cycles with no request on any channel
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;     // pipeline drain margin after the last verdict
    localparam int HDR_BYTES     = 20;

    // days before the first of each month, non-leap year
    localparam int CUM_DAYS [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    video_frame_chain_carver_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 time unit period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Carver predictor state. Mirrors what the block must hold: the header
    // window, the skip count of a frame taken whole, and the open chain.
    // ------------------------------------------------------------------
    cfg_t        cur_cfg = '{RST_MAX_FRAME_LEN, RST_GAP_SECONDS, RST_START_TYPE,
                             RST_MAX_CHANNEL};
    logic [7:0]  hwin [HDR_BYTES];
    int          hwin_fill   = 0;
    logic [31:0] next_ofs    = '0;   // offset of the next byte in the image
    logic [23:0] skip_left   = '0;
    bit          chain_open  = 1'b0;
    logic [15:0] chain_chan  = '0;
    logic [30:0] chain_secs  = '0;
    logic [31:0] chain_head  = '0;   // magic offset of the chain's first frame
    logic [31:0] chain_tail  = '0;   // end offset of the chain's last frame

    result_t pending_reports [$];    // verdicts predicted, not yet seen on m_*
    int      mismatches        = 0;
    int      bytes_sent        = 0;
    int      reports_predicted = 0;

    // idle and stall control, written by the test sequence
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_orders   = 0;

    // generator-side wall clock used to build plausible time words
    int          ts_year, ts_mon, ts_day, ts_hour, ts_min, ts_sec;
    logic [31:0] stale_word = '0;

    // Time word -> seconds since 2000-01-01 UTC; returns 0 on a bad time.
    // Out-of-range days simply fall through the civil arithmetic.
    function automatic bit time_to_secs(input logic [31:0] w, output logic [30:0] secs);
        int     yo, mo, dy, hh, mi, ss;
        longint days, total;
        yo   = int'(w[31:26]);
        mo   = int'(w[25:22]);
        dy   = int'(w[21:17]);
        hh   = int'(w[16:12]);
        mi   = int'(w[11:6]);
        ss   = int'(w[5:0]);
        secs = '0;
        if (hh > int'(HOUR_MAX) || mi > int'(MINSEC_MAX) || ss > int'(MINSEC_MAX) ||
            mo < 1 || mo > int'(MONTH_MAX))
            return 1'b0;
        days = 365 * yo + (yo + 3) / 4 + CUM_DAYS[mo - 1] + dy - 1;
        if (yo % 4 == 0 && mo > int'(MONTH_FEB))
            days++;
        total = days * 86400 + hh * 3600 + mi * 60 + ss;
        if (total < 0)
            total = 0;   // before the epoch saturates
        secs = total[30:0];
        return 1'b1;
    endfunction

    function automatic logic [31:0] pack_time(input int yo, mo, dy, hh, mi, ss);
        return {yo[5:0], mo[3:0], dy[4:0], hh[4:0], mi[5:0], ss[5:0]};
    endfunction

    // One accepted byte through the predictor; queues a verdict if it causes one.
    task automatic carve_byte(input logic [7:0] b);
        logic [31:0] at, len32, tword, tail;
        logic [15:0] kind, chan;
        logic [30:0] secs;
        longint      diff;
        bit          taken;
        result_t     r;
        int          i;
        if (skip_left != 0) begin
            skip_left--;
            next_ofs++;
            return;
        end
        if (hwin_fill < HDR_BYTES) begin
            hwin[hwin_fill] = b;
            hwin_fill++;
        end else begin
            for (i = 0; i < HDR_BYTES - 1; i++)
                hwin[i] = hwin[i + 1];
            hwin[HDR_BYTES - 1] = b;
        end
        at       = next_ofs - (HDR_BYTES - 1);
        next_ofs = next_ofs + 1;
        if (hwin_fill < HDR_BYTES || hwin[0] != MAGIC_B0 || hwin[1] != MAGIC_B1 ||
            hwin[2] != MAGIC_B2 || hwin[3] != MAGIC_B3)
            return;
        len32 = {hwin[15], hwin[14], hwin[13], hwin[12]};
        if (len32 > {8'd0, cur_cfg.max_len} || len32 < HDR_BYTES)
            return;
        kind  = {hwin[5], hwin[4]};
        chan  = {hwin[7], hwin[6]};
        tword = {hwin[19], hwin[18], hwin[17], hwin[16]};
        tail  = at + len32;
        taken = 1'b0;
        r     = '0;
        if (!time_to_secs(tword, secs)) begin
            r.verdict = VD_BAD_TIME;
            secs      = '0;
            taken     = 1'b1;
        end else if (chan > cur_cfg.max_chan) begin
            r.verdict = VD_BAD_CHAN;
            taken     = 1'b1;
        end else begin
            if (chain_open) begin
                diff = longint'(secs) - longint'(chain_secs);
                if (diff < longint'(cur_cfg.gap) && chan == chain_chan) begin
                    r.verdict = VD_CONTINUED;
                    taken     = 1'b1;
                end else begin
                    r.cstart   = chain_head;
                    r.cend     = chain_tail;
                    chain_open = 1'b0;
                    if (kind == cur_cfg.start_type) begin
                        r.verdict  = VD_CLOSED_RESTRT;
                        chain_open = 1'b1;
                        chain_head = at;
                        taken      = 1'b1;
                    end else begin
                        r.verdict = VD_CLOSED_IDLE;
                    end
                end
            end else if (kind == cur_cfg.start_type) begin
                r.verdict  = VD_STARTED;
                chain_open = 1'b1;
                chain_head = at;
                taken      = 1'b1;
            end else begin
                r.verdict = VD_NOT_START;
            end
            if (taken) begin
                chain_chan = chan;
                chain_secs = secs;
                chain_tail = tail;
            end
        end
        if (taken) begin
            skip_left = len32[23:0] - 24'(HDR_BYTES);
            hwin_fill = 0;
        end
        r.ofs  = at;
        r.len  = len32[23:0];
        r.chan = chan;
        r.secs = secs;
        pending_reports.push_back(r);
        reports_predicted++;
    endtask

    // ------------------------------------------------------------------
    // Input side. Entered at a falling edge; returns at a falling edge with
    // s_tvalid still high, so callers lower it before any wait.
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        carve_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [15:0] kind, input logic [15:0] chan,
                              input logic [31:0] len32, input logic [31:0] tword,
                              input int body);
        logic [7:0] hdr [HDR_BYTES];
        int         i;
        hdr[0]  = MAGIC_B0;
        hdr[1]  = MAGIC_B1;
        hdr[2]  = MAGIC_B2;
        hdr[3]  = MAGIC_B3;
        hdr[4]  = kind[7:0];
        hdr[5]  = kind[15:8];
        hdr[6]  = chan[7:0];
        hdr[7]  = chan[15:8];
        for (i = 8; i < 12; i++)
            hdr[i] = 8'($urandom_range(0, 255));
        for (i = 0; i < 4; i++) begin
            hdr[12 + i] = len32[8*i +: 8];
            hdr[16 + i] = tword[8*i +: 8];
        end
        for (i = 0; i < HDR_BYTES; i++)
            push_byte(hdr[i]);
        for (i = 0; i < body; i++)
            push_byte(8'($urandom_range(0, 255)));
    endtask

    // Stop offering, wait for every predicted verdict, then let the pipeline
    // drain before the block counts as idle.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Writes all four registers back to back; block must be idle.
    task automatic program_regs(input cfg_t c);
        logic [CFG_IDX_W-1:0]  idx  [4];
        logic [CFG_DATA_W-1:0] vals [4];
        int                    k;
        idx  = '{REG_MAX_FRAME_LEN, REG_GAP_SECONDS, REG_START_TYPE, REG_MAX_CHANNEL};
        vals = '{c.max_len, 24'(c.gap), 24'(c.start_type), 24'(c.max_chan)};
        for (k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            @(posedge aclk);
            while (!cfg_ready)
                @(posedge aclk);
            case (idx[k])
                REG_MAX_FRAME_LEN: cur_cfg.max_len    = vals[k];
                REG_GAP_SECONDS:   cur_cfg.gap        = vals[k][GAP_W-1:0];
                REG_START_TYPE:    cur_cfg.start_type = vals[k][TYPE_W-1:0];
                REG_MAX_CHANNEL:   cur_cfg.max_chan   = vals[k][CHAN_W-1:0];
                default: ;
            endcase
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Generator wall clock; day kept at 28 or below so months roll cleanly.
    task automatic tick_clock(input int d);
        ts_sec += d;
        while (ts_sec > 59) begin
            ts_sec -= 60;
            ts_min++;
        end
        if (ts_min > 59) begin
            ts_min = 0;
            ts_hour++;
        end
        if (ts_hour > 23) begin
            ts_hour = 0;
            ts_day++;
        end
        if (ts_day > 28) begin
            ts_day = 1;
            ts_mon++;
        end
        if (ts_mon > 12) begin
            ts_mon  = 1;
            ts_year = (ts_year + 1) % 64;
        end
    endtask

    // Mostly well-formed frames that extend or break the open chain, with
    // noise, cut-off headers, bad fields and out-of-range lengths mixed in.
    task automatic random_frame();
        int          p, lmax, body, d, i;
        logic [31:0] len32, tword;
        logic [15:0] kind, chan;
        p = $urandom_range(99);
        if (p < 5) begin
            repeat ($urandom_range(1, 6))
                push_byte(($urandom_range(3) == 0) ? MAGIC_B0 : 8'($urandom_range(0, 255)));
            return;
        end
        if (p < 8) begin
            // header cut short: magic and a few bytes only
            push_byte(MAGIC_B0);
            push_byte(MAGIC_B1);
            push_byte(MAGIC_B2);
            push_byte(MAGIC_B3);
            repeat ($urandom_range(0, 10))
                push_byte(8'($urandom_range(0, 255)));
            return;
        end

        lmax = (int'(cur_cfg.max_len) < 48) ? int'(cur_cfg.max_len) : 48;
        p    = $urandom_range(99);
        if (p < 88)
            len32 = $urandom_range(HDR_BYTES, lmax);
        else if (p < 90)
            len32 = (cur_cfg.max_len < 400) ? 32'(cur_cfg.max_len) : 32'd400;
        else if (p < 95)
            len32 = 32'(cur_cfg.max_len) + 32'($urandom_range(1, 4));  // too long: no match
        else
            len32 = $urandom_range(0, HDR_BYTES - 1);                   // too short: no match
        if (len32 >= HDR_BYTES && len32 <= 32'(cur_cfg.max_len))
            body = len32 - HDR_BYTES;
        else
            body = $urandom_range(0, 8);

        kind = ($urandom_range(99) < 60) ? cur_cfg.start_type : 16'($urandom_range(0, 65535));

        p = $urandom_range(99);
        if (chain_open && p < 65)
            chan = chain_chan;
        else if (p < 92 || cur_cfg.max_chan == 16'hFFFF)
            chan = 16'($urandom_range(0, cur_cfg.max_chan));
        else
            chan = 16'($urandom_range(int'(cur_cfg.max_chan) + 1, 65535));

        p = $urandom_range(99);
        if (p < 6) begin
            tword = pack_time(ts_year, ts_mon, ts_day, ts_hour, ts_min, ts_sec);
            case ($urandom_range(3))
                0:       tword[16:12] = 5'($urandom_range(24, 31));
                1:       tword[11:6]  = 6'($urandom_range(60, 63));
                2:       tword[5:0]   = 6'($urandom_range(60, 63));
                default: tword[25:22] = $urandom_range(1) ? 4'd0 : 4'($urandom_range(13, 15));
            endcase
        end else if (p < 12) begin
            tword = $urandom();        // odd days, far years, often bad fields
        end else if (p < 18) begin
            tword = stale_word;        // older than the chain's last frame
        end else begin
            if ($urandom_range(99) < 75)
                d = $urandom_range(0, int'(cur_cfg.gap) - 1);
            else
                d = $urandom_range(int'(cur_cfg.gap), int'(cur_cfg.gap) + 3);
            tick_clock(d);
            tword = pack_time(ts_year, ts_mon, ts_day, ts_hour, ts_min, ts_sec);
        end
        if ($urandom_range(9) == 0)
            stale_word = pack_time(ts_year, ts_mon, ts_day, ts_hour, ts_min, ts_sec);
        send_frame(kind, chan, len32, tword, body);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short hand-built sequence: one frame per verdict and per special case.
    task automatic test_directed_frames();
        program_regs('{RST_MAX_FRAME_LEN, RST_GAP_SECONDS, RST_START_TYPE, RST_MAX_CHANNEL});
        push_byte(8'h00);
        push_byte(8'hFF);
        // idle and not a start type: window only slides
        send_frame(16'd7, 16'd0, 20, pack_time(0, 1, 1, 0, 0, 0), 0);
        // start, day 0 of January 2000 lies before the epoch -> saturates
        send_frame(RST_START_TYPE, 16'd3, 20, pack_time(0, 1, 0, 0, 0, 0), 0);
        send_frame(16'hFFFF, 16'd3, 20, pack_time(0, 1, 0, 0, 0, 1), 0);
        // bad times: hour, minute, second, month zero, month thirteen
        send_frame(RST_START_TYPE, 16'd3, 20, pack_time(5, 6, 7, 24, 0, 0), 0);
        send_frame(RST_START_TYPE, 16'd3, 20, pack_time(5, 6, 7, 0, 60, 0), 0);
        send_frame(RST_START_TYPE, 16'd3, 20, pack_time(5, 6, 7, 0, 0, 60), 0);
        send_frame(RST_START_TYPE, 16'd3, 20, pack_time(5, 0, 7, 0, 0, 0), 0);
        send_frame(RST_START_TYPE, 16'd3, 20, pack_time(5, 13, 7, 0, 0, 0), 0);
        // channel above the limit
        send_frame(RST_START_TYPE, 16'hFFFF, 20, pack_time(0, 1, 1, 0, 0, 0), 0);
        // lengths out of range: no match
        send_frame(RST_START_TYPE, 16'd3, 19, pack_time(0, 1, 1, 0, 0, 0), 0);
        send_frame(RST_START_TYPE, 16'd3, 32'(RST_MAX_FRAME_LEN) + 1,
                   pack_time(0, 1, 1, 0, 0, 0), 0);
        // large time step closes the chain and a start reopens it
        send_frame(RST_START_TYPE, 16'd3, 20, pack_time(0, 3, 1, 0, 0, 10), 0);
        // older than the previous frame still continues
        send_frame(16'd0, 16'd3, 20, pack_time(0, 3, 1, 0, 0, 5), 0);
        // other channel, not a start: closed and idle
        send_frame(16'd9, 16'd4, 20, pack_time(0, 3, 1, 0, 0, 6), 0);
        // latest time the word can hold, with a payload to skip
        send_frame(RST_START_TYPE, 16'd15, 24, pack_time(63, 12, 31, 23, 59, 59), 4);
        // February 31st in a leap year normalizes into March
        send_frame(16'd1, 16'd15, 20, pack_time(4, 2, 31, 0, 0, 0), 0);
        send_frame(16'd1, 16'd15, 20, pack_time(4, 3, 1, 12, 0, 0), 0);
        // difference equal to the gap breaks the chain
        send_frame(16'd1, 16'd15, 20, pack_time(4, 3, 1, 12, 0, 2), 0);
        settle_idle();
    endtask

    // Receiver holds off while bad-channel frames keep coming, so the result
    // buffer fills and the input side must stall.
    task automatic test_result_backpressure();
        int n;
        hold_orders++;
        for (n = 0; n < 6; n++)
            send_frame(RST_START_TYPE, 16'd200, 20, pack_time(1, 2, 3, 4, 5, n), 0);
        settle_idle();
    endtask

    // Sender stops mid-chain until every verdict is out, then resumes it.
    task automatic test_pause_until_drained();
        send_frame(RST_START_TYPE, 16'd2, 24, pack_time(9, 9, 9, 9, 9, 9), 4);
        send_frame(16'd5, 16'd2, 20, pack_time(9, 9, 9, 9, 9, 10), 0);
        settle_idle();
        send_frame(16'd5, 16'd2, 22, pack_time(9, 9, 9, 9, 9, 10), 2);
        send_frame(16'd5, 16'd2, 20, pack_time(9, 9, 9, 9, 9, 30), 0);
        settle_idle();
    endtask

    task automatic test_random_phase(input cfg_t c, input int idle_pct, input int stall,
                                     input int byte_goal, input int report_goal);
        int start_bytes, start_reports;
        settle_idle();
        program_regs(c);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        ts_year       = $urandom_range(0, 63);
        ts_mon        = $urandom_range(1, 12);
        ts_day        = $urandom_range(1, 28);
        ts_hour       = $urandom_range(0, 23);
        ts_min        = $urandom_range(0, 59);
        ts_sec        = $urandom_range(0, 59);
        stale_word    = pack_time(ts_year, ts_mon, ts_day, ts_hour, ts_min, ts_sec);
        start_bytes   = bytes_sent;
        start_reports = reports_predicted;
        while (bytes_sent - start_bytes < byte_goal ||
               reports_predicted - start_reports < report_goal)
            random_frame();
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off per request from
    // the test sequence, counted here in cycles.
    // ------------------------------------------------------------------
    int hold_taken = 0;
    int hold_left  = 0;

    always @(negedge aclk) begin
        if (hold_orders != hold_taken) begin
            hold_taken = hold_orders;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got, input logic [31:0] at);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("verdict for frame at %0d: %s expected %0h, actual %0h",
                         at, name, want, got);
        end
    endfunction

    // Every accepted result is matched against the oldest prediction.
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[169:0]);
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected verdict %0d for frame at %0d", got.verdict, got.ofs);
            end else begin
                want = pending_reports.pop_front();
                check_field("verdict",            want.verdict, got.verdict, want.ofs);
                check_field("frame_offset",       want.ofs,     got.ofs,     want.ofs);
                check_field("frame_length",       want.len,     got.len,     want.ofs);
                check_field("channel_number",     want.chan,    got.chan,    want.ofs);
                check_field("frame_seconds",      want.secs,    got.secs,    want.ofs);
                check_field("closed_chain_start", want.cstart,  got.cstart,  want.ofs);
                check_field("closed_chain_end",   want.cend,    got.cend,    want.ofs);
                check_field("pad bits",           '0,           m_tdata[175:170], want.ofs);
            end
        end
    end

    // Watchdog: too long without any request on any channel ends the run.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset once, directed checks, pressure cases, then four
    // random phases covering register extremes and every idling pattern.
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_frames();
        test_result_backpressure();
        test_pause_until_drained();
        // no idling, reset register values
        test_random_phase('{RST_MAX_FRAME_LEN, RST_GAP_SECONDS, RST_START_TYPE,
                            RST_MAX_CHANNEL}, 0, 0, 50, 2);
        // low extremes, sender idle most cycles
        test_random_phase('{24'd24, 8'd1, 16'd0, 16'd0}, 63, 0, 50, 2);
        // high extremes, receiver stalling most cycles
        test_random_phase('{24'hFFFFFF, 8'd255, 16'hFFFF, 16'hFFFF}, 0, 63, 50, 2);
        // middle values, both sides idling now and then
        test_random_phase('{24'd1000, 8'd7, RST_START_TYPE, 16'd40}, 24, 24, 50, 2);

        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/vfcc_pkg.sv
design/vfcc_hdr_front.sv
design/vfcc_time_stage.sv
design/vfcc_chain_ctrl.sv
design/vfcc_out_buf.sv
design/video_frame_chain_carver_unit.sv
bench/testbench.sv
